[hdl/dsdp_pkg.sv]
`timescale 1ns / 1ps
package dsdp_pkg;

    localparam int DSDP_HALF_TAPS    = 48;
    localparam int DSDP_TABLE_GROUPS = 6;

    localparam int COEF_W   = 24;
    localparam int TERM_W   = COEF_W + 1;
    // eight terms of up to 2^24 each reach +2^27, one bit past a 28-bit signed range
    localparam int PART_W   = TERM_W + 4;
    localparam int ACC_W    = PART_W + 3;
    localparam int SAMPLE_W = 32;
    localparam int APB_AW   = 4;

    localparam logic [7:0] DSD_SILENCE = 8'h69;

    typedef enum logic [1:0] {
        REG_LSB_FIRST  = 2'd0,
        REG_COEF_INDEX = 2'd1,
        REG_COEF_VALUE = 2'd2,
        REG_NONE       = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_stat_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = b[7-k];
        end
        return r;
    endfunction

endpackage

[hdl/dsdp_stream_if.sv]
`timescale 1ns / 1ps
interface dsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] dsd_byte;
    modport source (output valid, output dsd_byte, input ready);
    modport sink (input valid, input dsd_byte, output ready);
endinterface

interface pcm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pcm_sample;
    modport source (output valid, output pcm_sample, input ready);
    modport sink (input valid, input pcm_sample, output ready);
endinterface

[hdl/dsdp_front.sv]
`timescale 1ns / 1ps
module dsdp_front
    import dsdp_pkg::*;
#(
    parameter int TABLE_GROUPS = DSDP_TABLE_GROUPS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    dsd_in_if.sink                dsd_in,
    input  logic                  lsb_first,
    input  logic signed [COEF_W-1:0] coef [TABLE_GROUPS*8],
    input  q_stat_t               q_stat,
    output logic                  push,
    output logic [TABLE_GROUPS-1:0][PART_W-1:0] push_data
);
    localparam int TAPS = 2 * TABLE_GROUPS;

    logic [7:0] tap_reg [TAPS];
    logic       busy_reg, busy_next;
    logic       accept;

    assign push         = busy_reg && q_stat.not_full;
    assign dsd_in.ready = !busy_reg || q_stat.not_full;
    assign accept       = dsd_in.valid && dsd_in.ready;
    assign busy_next    = accept ? 1'b1 : (push ? 1'b0 : busy_reg);

    // shift line holds the window; a byte is reversed as it reaches the older half
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            for (int a = 0; a < TAPS; a++)
            begin
                tap_reg[a] <= DSD_SILENCE;
            end
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
            begin
                tap_reg[0] <= lsb_first ? rev8(dsd_in.dsd_byte) : dsd_in.dsd_byte;
                for (int a = 1; a < TAPS; a++)
                begin
                    if (a == TABLE_GROUPS)
                        tap_reg[a] <= rev8(tap_reg[a-1]);
                    else
                        tap_reg[a] <= tap_reg[a-1];
                end
            end
        end
    end

    // each coefficient sees one newer and one older bit: +2c, -2c or nothing
    always_comb
    begin
        logic signed [PART_W-1:0] psum;
        logic signed [TERM_W-1:0] c2;
        logic                     bn, bo;
        for (int grp = 0; grp < TABLE_GROUPS; grp++)
        begin
            psum = '0;
            for (int m = 0; m < 8; m++)
            begin
                bn = tap_reg[TABLE_GROUPS-1-grp][7-m];
                bo = tap_reg[TABLE_GROUPS+grp][7-m];
                c2 = {coef[grp*8+m], 1'b0};
                if (bn && bo)
                    psum = psum + PART_W'(c2);
                else if (!bn && !bo)
                    psum = psum - PART_W'(c2);
            end
            push_data[grp] = psum;
        end
    end
endmodule

[hdl/dsdp_fifo.sv]
`timescale 1ns / 1ps
module dsdp_fifo
    import dsdp_pkg::*;
#(
    parameter int TABLE_GROUPS = DSDP_TABLE_GROUPS
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [TABLE_GROUPS-1:0][PART_W-1:0] push_data,
    input  logic                                pop,
    output logic [TABLE_GROUPS-1:0][PART_W-1:0] pop_data,
    output q_stat_t                             q_stat
);
    logic [TABLE_GROUPS-1:0][PART_W-1:0] entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign q_stat.not_empty = (count_reg != 2'd0);
    assign q_stat.not_full  = (count_reg != 2'd2);
    assign pop_data         = entry_reg[rd_ptr_reg];
    assign count_next       = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end
endmodule

[hdl/dsdp_back.sv]
`timescale 1ns / 1ps
module dsdp_back
    import dsdp_pkg::*;
#(
    parameter int TABLE_GROUPS = DSDP_TABLE_GROUPS
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  q_stat_t                             q_stat,
    input  logic [TABLE_GROUPS-1:0][PART_W-1:0] pop_data,
    output logic                                pop,
    pcm_out_if.source                           pcm_out
);
    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] pcm_reg, pcm_next;
    logic signed [ACC_W-1:0]    acc;

    assign pop = q_stat.not_empty && (!valid_reg || pcm_out.ready);

    always_comb
    begin
        acc = '0;
        for (int g = 0; g < TABLE_GROUPS; g++)
        begin
            acc = acc + ACC_W'($signed(pop_data[g]));
        end
        // the group sum cannot leave the 32-bit range, so the plain cast needs no saturation
        pcm_next = SAMPLE_W'(acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (pcm_out.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            pcm_reg <= pcm_next;
    end

    assign pcm_out.valid      = valid_reg;
    assign pcm_out.pcm_sample = pcm_reg;
endmodule

[hdl/dsd_to_pcm_decimator_core.sv]
`timescale 1ns / 1ps
// channel   dir  protocol     word
// dsd_in    in   valid/ready  dsd_byte [7:0], eight dsd bits
// pcm_out   out  valid/ready  pcm_sample [31:0], signed q9.22 sample
// apb       in   apb write    lsb_first, coef_index, coef_value at 0x0, 0x4, 0x8
//
// one word per cycle sustained while pcm_out takes them; each dsd word gives one pcm word
// through the window register, the two-entry queue and the output register
// reset loads the window with the 0x69 silence pattern and zeroes the coefficients
// a stalled pcm_out fills the queue; dsd_in stalls only once queue and window are full
module dsd_to_pcm_decimator_core
    import dsdp_pkg::*;
#(
    parameter int HALF_TAPS    = DSDP_HALF_TAPS,
    parameter int TABLE_GROUPS = DSDP_TABLE_GROUPS
)(
    input  logic              clk,
    input  logic              rst_n,
    dsd_in_if.sink            dsd_in,
    pcm_out_if.source         pcm_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int SLOTS = TABLE_GROUPS * 8;

    logic                     lsb_first_reg;
    logic [5:0]               coef_index_reg;
    logic signed [COEF_W-1:0] coef_value_reg;
    logic signed [COEF_W-1:0] coef_reg [HALF_TAPS];
    logic signed [COEF_W-1:0] coef_pad [SLOTS];
    logic                     wr;
    reg_index_t               widx;

    q_stat_t                             q_stat;
    logic                                push, pop;
    logic [TABLE_GROUPS-1:0][PART_W-1:0] push_data, pop_data;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign widx   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsb_first_reg  <= 1'b0;
            coef_index_reg <= 6'd0;
            coef_value_reg <= '0;
        end
        else if (wr)
        begin
            case (widx)
                REG_LSB_FIRST:  lsb_first_reg  <= pwdata[0];
                REG_COEF_INDEX: coef_index_reg <= pwdata[5:0];
                REG_COEF_VALUE: coef_value_reg <= pwdata[COEF_W-1:0];
                default:        ;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < HALF_TAPS; i++)
        begin : g_coef
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    coef_reg[i] <= '0;
                else if (wr && widx == REG_COEF_VALUE && coef_index_reg == 6'(i))
                    coef_reg[i] <= pwdata[COEF_W-1:0];
            end
        end
        // taps past the half filter read as zero
        for (i = 0; i < SLOTS; i++)
        begin : g_pad
            if (i < HALF_TAPS)
            begin : g_live
                assign coef_pad[i] = coef_reg[i];
            end
            else
            begin : g_zero
                assign coef_pad[i] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        case (reg_index_t'(paddr[3:2]))
            REG_LSB_FIRST:  prdata = {31'd0, lsb_first_reg};
            REG_COEF_INDEX: prdata = {26'd0, coef_index_reg};
            REG_COEF_VALUE: prdata = 32'($signed(coef_value_reg));
            default:        prdata = 32'd0;
        endcase
    end

    dsdp_front #(.TABLE_GROUPS(TABLE_GROUPS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dsd_in    (dsd_in),
        .lsb_first (lsb_first_reg),
        .coef      (coef_pad),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    dsdp_fifo #(.TABLE_GROUPS(TABLE_GROUPS)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    dsdp_back #(.TABLE_GROUPS(TABLE_GROUPS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .pcm_out  (pcm_out)
    );

    a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.not_full || q_stat.not_empty)
        else $error("queue reports full and empty");

    a_out_from_q: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pcm_out.valid) |-> $past(q_stat.not_empty))
        else $error("output word without queued partials");

    a_lsb_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr && widx == REG_LSB_FIRST |=> lsb_first_reg == $past(pwdata[0]))
        else $error("lsb_first write lost");
endmodule

[tb/sv/dsd_to_pcm_decimator_core_tb.sv]
`timescale 1ns / 1ps
module dsd_to_pcm_decimator_core_tb;
    import dsdp_pkg::*;

    localparam int NTAPS  = DSDP_HALF_TAPS;
    localparam int NGRP   = DSDP_TABLE_GROUPS;
    localparam int RDEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    dsd_in_if dsd_in ();
    pcm_out_if pcm_out ();

    initial
    begin
        dsd_in.valid = 1'b0;
        dsd_in.dsd_byte = '0;
        pcm_out.ready = 1'b0;
    end

    dsd_to_pcm_decimator_core DUT (
        .clk(clk), .rst_n(rst_n), .dsd_in(dsd_in), .pcm_out(pcm_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [7:0]         win_bytes [RDEPTH];
    logic [3:0]         win_ptr;
    logic signed [23:0] taps [NTAPS];
    logic               lsb_mode;
    logic [5:0]         tap_sel;

    logic signed [31:0] pcm_expected [$];
    int errors = 0;
    int bytes_sent = 0;
    int samples_seen = 0;
    int idle_cycles = 0;
    bit hold_sink = 1'b0;
    bit burst_mode = 1'b0;

    function automatic logic [7:0] flip_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = b[7-k];
        end
        return r;
    endfunction

    function automatic longint byte_term(input int grp, input logic [7:0] b);
        longint acc;
        int n;
        acc = 0;
        n = NTAPS - grp * 8;
        if (n > 8)
        begin
            n = 8;
        end
        for (int m = 0; m < n; m++)
        begin
            if (b[7-m])
                acc += taps[grp*8+m];
            else
                acc -= taps[grp*8+m];
        end
        return acc;
    endfunction

    task automatic filter_byte(input logic [7:0] b);
        longint acc;
        int grp;
        logic [3:0] aged;
        acc = 0;
        win_bytes[win_ptr] = lsb_mode ? flip_byte(b) : b;
        aged = 4'(win_ptr - NGRP);
        win_bytes[aged] = flip_byte(win_bytes[aged]);
        for (int g = 0; g < NGRP; g++)
        begin
            grp = NGRP - 1 - g;
            acc += byte_term(grp, win_bytes[4'(win_ptr - g)]);
            acc += byte_term(grp, win_bytes[4'(win_ptr - (2*NGRP - 1 - g))]);
        end
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        else if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        pcm_expected.push_back(32'(acc));
        win_ptr = 4'(win_ptr + 1);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // valid stays up between back-to-back words; a gap or drain drops it
    task automatic send_byte(input logic [7:0] b);
        int g;
        g = burst_mode ? 0 : gap_len();
        if (g > 0)
        begin
            dsd_in.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        dsd_in.valid <= 1'b1;
        dsd_in.dsd_byte <= b;
        @(posedge clk);
        while (!dsd_in.ready)
        begin
            @(posedge clk);
        end
        filter_byte(b);
        bytes_sent++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LSB_FIRST:  lsb_mode = val[0];
            REG_COEF_INDEX: tap_sel = val[5:0];
            REG_COEF_VALUE:
            begin
                if (tap_sel < NTAPS)
                    taps[tap_sel] = val[23:0];
            end
            default: ;
        endcase
    endtask

    task automatic drain();
        dsd_in.valid <= 1'b0;
        while (pcm_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic load_taps(input int mode);
        logic [31:0] v;
        for (int i = 0; i < NTAPS; i++)
        begin
            case (mode)
                0: v = 32'h007FFFFF;
                1: v = 32'hFF800000;
                2: v = 32'(i * 1000 - 20000);
                default: v = $urandom();
            endcase
            write_reg(REG_COEF_INDEX, 32'(i));
            write_reg(REG_COEF_VALUE, v);
        end
    endtask

    // sink side: random ready, plus long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_sink)
            pcm_out.ready <= 1'b0;
        else
            pcm_out.ready <= ($urandom_range(0, 99) < 70) || burst_mode;
        if (pcm_out.valid && pcm_out.ready)
        begin
            samples_seen++;
            if (pcm_expected.size() == 0)
            begin
                $display("%0t: unexpected pcm word, expected none, actual %0d", $time,
                    $signed(pcm_out.pcm_sample));
                errors++;
            end
            else
            begin
                if ($signed(pcm_out.pcm_sample) !== pcm_expected[0])
                begin
                    $display("%0t: pcm_sample mismatch, expected %0d, actual %0d", $time,
                        pcm_expected[0], $signed(pcm_out.pcm_sample));
                    errors++;
                end
                void'(pcm_expected.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((dsd_in.valid && dsd_in.ready) || (pcm_out.valid && pcm_out.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("[dsd_to_pcm_decimator_core] ERROR");
            $finish;
        end
    end

    task automatic test_unloaded();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h69);
        drain();
    endtask

    task automatic test_extremes();
        load_taps(0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        repeat (8) send_byte(8'hFF);
        repeat (8) send_byte(8'h00);
        drain();
        load_taps(1);
        repeat (4) send_byte(8'h00);
        send_byte(8'h5A);
        drain();
    endtask

    task automatic test_index_range();
        load_taps(2);
        // out of range index 63 leaves the table alone; a wide index keeps only its low six bits
        write_reg(REG_COEF_INDEX, 32'd63);
        write_reg(REG_COEF_VALUE, 32'h00123456);
        write_reg(REG_COEF_INDEX, 32'hFFFFFFC5);
        write_reg(REG_COEF_VALUE, 32'hABCDEF01);
        write_reg(REG_NONE, 32'hFFFFFFFF);
        send_byte(8'h81);
        send_byte(8'h7E);
        drain();
    endtask

    task automatic test_lsb_first();
        write_reg(REG_LSB_FIRST, 32'hFFFFFFFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h3C);
        drain();
        write_reg(REG_LSB_FIRST, 32'h0);
        drain();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            load_taps(p % 2 == 0 ? 3 : 2);
            write_reg(REG_LSB_FIRST, $urandom_range(0, 1));
            burst_mode = (p % 3 == 2);
            for (int i = 0; i < per_phase; i++)
            begin
                send_byte($urandom_range(0, 255));
            end
            burst_mode = 1'b0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        int n;
        burst_mode = 1'b1;
        hold_sink = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_sink = 1'b0;
            end
            for (n = 0; n < 40; n++)
            begin
                send_byte($urandom_range(0, 255));
            end
        join
        burst_mode = 1'b0;
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < RDEPTH; i++)
        begin
            win_bytes[i] = DSD_SILENCE;
        end
        for (int i = 0; i < NTAPS; i++)
        begin
            taps[i] = '0;
        end
        win_ptr = '0;
        lsb_mode = 1'b0;
        tap_sel = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_unloaded();
        test_extremes();
        test_index_range();
        test_lsb_first();
        test_backpressure();
        test_random(6, 210);
        drain();
        $display("covered %0d dsd words and %0d pcm words: extreme and random taps,",
            bytes_sent, samples_seen);
        $display("lsb-first mode, out-of-range index writes and a long output stall");
        if (errors == 0)
            $display("[dsd_to_pcm_decimator_core] OK");
        else
            $display("[dsd_to_pcm_decimator_core] ERROR");
        $finish;
    end

endmodule
